FILE: hdl/rmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg: shared constants, types and helpers
// Tree geometry, node value limits, action codes and controller state codes
// for the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

    // Tree geometry: LEAVES leaves padded to PADDED = 2**LEVELS
    localparam int LEAVES    = 1024;
    localparam int LEVELS    = $clog2(LEAVES);
    localparam int PADDED    = 1 << LEVELS;
    localparam int RAM_DEPTH = 2 * PADDED;
    localparam int ADDR_W    = LEVELS + 1;
    localparam int IDX_W     = LEVELS + 2;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 10;
    localparam int BOUND_W   = 11;

    localparam logic signed [DATA_W-1:0] NODE_MAX = 32'sh7FFF_FFFF;

    // Action codes
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_CLR   = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ULEAF = 6'b000100,
        ST_UUP   = 6'b001000,
        ST_QL    = 6'b010000,
        ST_QR    = 6'b100000
    } state_t;

    // Signed minimum of two nodes
    function automatic logic signed [DATA_W-1:0] min_node(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        min_node = (a < b) ? a : b;
    endfunction

endpackage

FILE: hdl/rmst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/range_min_segment_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree: range-minimum segment tree
// Keeps signed 32-bit minima over 1024 leaves in a heap-ordered node RAM.
// Updates write a leaf and walk its ancestors to the root; queries walk the
// tree bottom-up over a half-open leaf range and return one word.
//
// Channel   Ports                                              Handshake
// input     action leaf_position new_value range_start         start & !busy
//           range_end
// result    range_minimum                                      done (1 cycle)
//
// Update: one read-modify-write of the node RAM per tree level, through its
//   single read port.
// Query: a left-bound step and a right-bound step per tree level, each reading at most one node.
// Reset: a clearing pass writes every node to the largest positive value,
//   with busy high.
// The result is on range_minimum while done is high and holds until the next
//   query is accepted; the block can take the next word while done is high.
// ----------------------------------------------------------------------------
module range_min_segment_tree (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  action,
    input  logic [rmst_pkg::POS_W-1:0]            leaf_position,
    input  logic signed [rmst_pkg::DATA_W-1:0]    new_value,
    input  logic [rmst_pkg::BOUND_W-1:0]          range_start,
    input  logic [rmst_pkg::BOUND_W-1:0]          range_end,
    output logic                                  done,
    output logic signed [rmst_pkg::DATA_W-1:0]    range_minimum
);

    rmst_pkg::state_t state_reg, state_next;

    logic [rmst_pkg::ADDR_W-1:0]        clr_reg, clr_next;
    logic [rmst_pkg::ADDR_W-1:0]        node_reg, node_next;
    logic signed [rmst_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic [rmst_pkg::IDX_W-1:0]         l_reg, l_next;
    logic [rmst_pkg::IDX_W-1:0]         r_reg, r_next;
    logic signed [rmst_pkg::DATA_W-1:0] res_reg, res_next;
    logic                               pend_reg, pend_next;
    logic                               done_reg, done_next;

    logic                               we;
    logic [rmst_pkg::ADDR_W-1:0]        waddr;
    logic signed [rmst_pkg::DATA_W-1:0] wdata;
    logic [rmst_pkg::ADDR_W-1:0]        raddr;
    logic [rmst_pkg::DATA_W-1:0]        rdata;

    logic [rmst_pkg::BOUND_W-1:0]       end_clamp;
    logic [rmst_pkg::ADDR_W-1:0]        parent;
    logic signed [rmst_pkg::DATA_W-1:0] up_min;
    logic signed [rmst_pkg::DATA_W-1:0] acc;
    logic [rmst_pkg::IDX_W-1:0]         r_dec;

    // Node store
    rmst_ram #(
        .WIDTH (rmst_pkg::DATA_W),
        .DEPTH (rmst_pkg::RAM_DEPTH)
    ) u_nodes (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Clamp the query end to the leaf count
    assign end_clamp = (range_end > rmst_pkg::BOUND_W'(rmst_pkg::LEAVES))
                     ? rmst_pkg::BOUND_W'(rmst_pkg::LEAVES) : range_end;

    // Ancestor step of an update
    assign parent = node_reg >> 1;
    assign up_min = rmst_pkg::min_node(cur_reg, $signed(rdata));

    // Fold in a node read issued last cycle
    assign acc = pend_reg ? rmst_pkg::min_node(res_reg, $signed(rdata)) : res_reg;

    // Right bound step of a query
    assign r_dec = r_reg[0] ? (r_reg - rmst_pkg::IDX_W'(1)) : r_reg;

    // Sequence clearing, updates and queries
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        cur_next   = cur_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        res_next   = acc;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = node_reg;
        wdata      = cur_reg;
        raddr      = node_reg;
        case (state_reg)
            rmst_pkg::ST_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = rmst_pkg::NODE_MAX;
                clr_next = clr_reg + rmst_pkg::ADDR_W'(1);
                if (clr_reg == rmst_pkg::ADDR_W'(rmst_pkg::RAM_DEPTH - 1))
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (action == rmst_pkg::ACT_UPDATE)
                    begin
                        if (rmst_pkg::ADDR_W'(leaf_position)
                            < rmst_pkg::ADDR_W'(rmst_pkg::LEAVES))
                        begin
                            node_next  = rmst_pkg::ADDR_W'(leaf_position)
                                       + rmst_pkg::ADDR_W'(rmst_pkg::PADDED);
                            cur_next   = new_value;
                            state_next = rmst_pkg::ST_ULEAF;
                        end
                    end
                    else
                    begin
                        l_next     = rmst_pkg::IDX_W'(range_start)
                                   + rmst_pkg::IDX_W'(rmst_pkg::PADDED);
                        r_next     = rmst_pkg::IDX_W'(end_clamp)
                                   + rmst_pkg::IDX_W'(rmst_pkg::PADDED);
                        res_next   = rmst_pkg::NODE_MAX;
                        state_next = rmst_pkg::ST_QL;
                    end
                end
            end
            rmst_pkg::ST_ULEAF:
            begin
                // Write the leaf, fetch its sibling
                we    = 1'b1;
                waddr = node_reg;
                wdata = cur_reg;
                raddr = node_reg ^ rmst_pkg::ADDR_W'(1);
                if (node_reg == rmst_pkg::ADDR_W'(1))
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rmst_pkg::ST_UUP;
                end
            end
            rmst_pkg::ST_UUP:
            begin
                // Write the parent, fetch the parent's sibling
                we        = 1'b1;
                waddr     = parent;
                wdata     = up_min;
                cur_next  = up_min;
                node_next = parent;
                raddr     = parent ^ rmst_pkg::ADDR_W'(1);
                if (parent == rmst_pkg::ADDR_W'(1))
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_QL:
            begin
                if (l_reg >= r_reg)
                begin
                    done_next  = 1'b1;
                    state_next = rmst_pkg::ST_IDLE;
                end
                else
                begin
                    if (l_reg[0])
                    begin
                        raddr     = l_reg[rmst_pkg::ADDR_W-1:0];
                        l_next    = l_reg + rmst_pkg::IDX_W'(1);
                        pend_next = 1'b1;
                    end
                    state_next = rmst_pkg::ST_QR;
                end
            end
            rmst_pkg::ST_QR:
            begin
                if (r_reg[0])
                begin
                    raddr     = r_dec[rmst_pkg::ADDR_W-1:0];
                    pend_next = 1'b1;
                end
                l_next     = l_reg >> 1;
                r_next     = r_dec >> 1;
                state_next = rmst_pkg::ST_QL;
            end
            default:
            begin
                state_next = rmst_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmst_pkg::ST_CLR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign busy          = (state_reg != rmst_pkg::ST_IDLE);
    assign done          = done_reg;
    assign range_minimum = res_reg;

`ifndef SYNTHESIS
    // A result follows only the end of a query walk
    a_done_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == rmst_pkg::ST_QL))
        else $error("result strobe without finished query");

    // Queries never write the node store
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmst_pkg::ST_QL || state_reg == rmst_pkg::ST_QR) |-> !we)
        else $error("node write during query");

    // An accepted in-range update starts at its leaf
    a_update_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == rmst_pkg::ACT_UPDATE
         && rmst_pkg::ADDR_W'(leaf_position) < rmst_pkg::ADDR_W'(rmst_pkg::LEAVES))
        |=> (state_reg == rmst_pkg::ST_ULEAF))
        else $error("update did not start at leaf");

    // An update climb ends in idle
    a_update_climb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmst_pkg::ST_UUP)
        |=> (state_reg == rmst_pkg::ST_UUP || state_reg == rmst_pkg::ST_IDLE))
        else $error("update climb left its path");
`endif

endmodule
